// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== sv/lbpg_pkg.sv =====
`default_nettype none

package lbpg_pkg;

   typedef enum logic [3:0] {
      MODE_OFF          = 4'd0,
      MODE_ON           = 4'd1,
      MODE_BLINK_SLOW   = 4'd2,
      MODE_BLINK_MID    = 4'd3,
      MODE_BLINK_FAST   = 4'd4,
      MODE_BLINK_VFAST  = 4'd5,
      MODE_DOUBLE       = 4'd6,
      MODE_TRIPLE       = 4'd7,
      MODE_HEART        = 4'd8,
      MODE_PULSE        = 4'd9,
      MODE_SOS          = 4'd10
   } mode_type;

   // Register indexes on the configuration port.
   localparam logic CSR_PATTERN_MODE  = 1'b0;
   localparam logic CSR_INVERT_OUTPUT = 1'b1;

   localparam int ModeWidth   = 4;
   localparam int DivWidth    = 7;
   localparam int StepWidth   = 6;
   localparam int LevelWidth  = 8;
   localparam int CsrDataWidth = 4;

   localparam logic [DivWidth-1:0] MaxPeriod = 7'd100;

   localparam logic [StepWidth-1:0] SosLen       = 6'd37;
   localparam logic [StepWidth-1:0] DoubleCycle  = 6'd7;
   localparam logic [StepWidth-1:0] DoubleOn     = 6'd3;
   localparam logic [StepWidth-1:0] TripleCycle  = 6'd9;
   localparam logic [StepWidth-1:0] TripleOn     = 6'd5;
   localparam logic [StepWidth-1:0] HeartCycle   = 6'd10;
   localparam logic [StepWidth-1:0] HeartOn      = 6'd3;

   localparam logic [LevelWidth-1:0] PulseStep = 8'd5;
   localparam logic [LevelWidth-1:0] PulseTop  = 8'd250;
   localparam logic [LevelWidth-1:0] PulseMax  = 8'd255;

   // Morse SOS, one bit per 10-tick step, step 0 leftmost.
   localparam logic [0:36] SosPattern = 37'b1010100011101110111000101010000000000;

   typedef struct packed {
      logic [DivWidth-1:0]   tick_divider;
      logic [StepWidth-1:0]  step_index;
      logic                  led_on;
      logic [LevelWidth-1:0] pulse_level;
      logic                  pulse_rising;
   } pat_state_type;

   // Step period in ticks; zero means the mode never steps.
   function automatic logic [DivWidth-1:0] mode_period(input logic [ModeWidth-1:0] mode);
      logic [DivWidth-1:0] period;
      unique case (mode)
         MODE_BLINK_SLOW:  period = 7'd100;
         MODE_BLINK_MID:   period = 7'd50;
         MODE_BLINK_FAST:  period = 7'd20;
         MODE_BLINK_VFAST: period = 7'd10;
         MODE_DOUBLE:      period = 7'd15;
         MODE_TRIPLE:      period = 7'd15;
         MODE_HEART:       period = 7'd10;
         MODE_PULSE:       period = 7'd2;
         MODE_SOS:         period = 7'd10;
         default:          period = '0;
      endcase
      return period;
   endfunction

   // State after a fresh selection of a mode.
   function automatic pat_state_type fresh_state(input logic [ModeWidth-1:0] mode);
      pat_state_type st;
      st.tick_divider = '0;
      st.step_index   = '0;
      st.pulse_level  = '0;
      st.pulse_rising = 1'b1;
      st.led_on       = (mode >= MODE_ON) && (mode <= MODE_SOS) && (mode != MODE_PULSE);
      return st;
   endfunction

endpackage

`default_nettype wire

// ===== sv/led_blink_pattern_generator_top.sv =====
// A result is registered and shown in the cycle after its transaction is taken.
// One transaction per cycle unless rsp_ready holds it; the output register is the only stage.
// A new transaction is taken while a result waits, if that result leaves in the same cycle.
// Reset (synchronous, active high) selects mode off, no inversion and clears the pattern state.
`default_nettype none

`include "assert_macros.svh"

module led_blink_pattern_generator_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic                               csr_index,
   input  wire logic [lbpg_pkg::CsrDataWidth-1:0]  csr_wdata,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_restart,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_pin_level,
   output logic [lbpg_pkg::LevelWidth-1:0]         rsp_pwm_duty,
   output logic                                    rsp_pwm_active
);
   import lbpg_pkg::*;

   logic [ModeWidth-1:0]  mode_ff;
   logic                  invert_ff;
   pat_state_type         state_ff;
   pat_state_type         state_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  pin_ff;
   logic                  pin_in;
   logic [LevelWidth-1:0] duty_ff;
   logic [LevelWidth-1:0] duty_in;
   logic                  active_ff;
   logic                  active_in;
   logic                  req_take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   lbpg_step u_step (
      .mode       (mode_ff),
      .invert     (invert_ff),
      .restart    (req_restart),
      .state_cur  (state_ff),
      .state_nxt  (state_in),
      .pin_level  (pin_in),
      .pwm_duty   (duty_in),
      .pwm_active (active_in)
   );

   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         invert_ff    <= 1'b0;
         state_ff     <= fresh_state(MODE_OFF);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         // A mode write restarts the pattern as a fresh selection.
         if (csr_wr_en && (csr_index == CSR_PATTERN_MODE)) begin
            mode_ff  <= csr_wdata;
            state_ff <= fresh_state(csr_wdata);
         end else if (req_take) begin
            state_ff <= state_in;
         end
         if (csr_wr_en && (csr_index == CSR_INVERT_OUTPUT)) begin
            invert_ff <= csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pin_ff    <= pin_in;
         duty_ff   <= duty_in;
         active_ff <= active_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pin_level  = pin_ff;
   assign rsp_pwm_duty   = duty_ff;
   assign rsp_pwm_active = active_ff;

   `ASSERT_CLK(a_take_gives_rsp, clock, reset, req_take |=> rsp_valid_ff, "taken transaction gave no result")
   `ASSERT_NEVER(a_pwm_pin_low, clock, reset, rsp_valid_ff && active_ff && pin_ff, "pin high in pulse mode")
   `ASSERT_NEVER(a_duty_idle, clock, reset, rsp_valid_ff && !active_ff && (duty_ff != '0), "duty set outside pulse mode")
   `ASSERT_CLK(a_div_range, clock, reset, state_ff.tick_divider < MaxPeriod, "tick divider out of range")
   `ASSERT_CLK(a_step_range, clock, reset, state_ff.step_index < SosLen, "step index out of range")
   `ASSERT_CLK(a_ramp_range, clock, reset, state_ff.pulse_rising |-> (state_ff.pulse_level < PulseTop), "rising ramp past its top")

endmodule

`default_nettype wire

// ===== sv/lbpg_step.sv =====
`default_nettype none

module lbpg_step (
   input  wire logic [lbpg_pkg::ModeWidth-1:0]  mode,
   input  wire logic                            invert,
   input  wire logic                            restart,
   input  wire lbpg_pkg::pat_state_type         state_cur,
   output lbpg_pkg::pat_state_type              state_nxt,
   output logic                                 pin_level,
   output logic [lbpg_pkg::LevelWidth-1:0]      pwm_duty,
   output logic                                 pwm_active
);
   import lbpg_pkg::*;

   logic [DivWidth-1:0]    period;
   logic [DivWidth-1:0]    tick_inc;
   logic                   step_due;
   logic [StepWidth-1:0]   cycle_len;
   logic [StepWidth-1:0]   on_len;
   logic [StepWidth-1:0]   step_cur;
   logic [StepWidth-1:0]   step_inc;
   logic [LevelWidth:0]    level_up;
   pat_state_type          stepped;

   assign period   = mode_period(mode);
   // Divider never exceeds 99, so the increment fits in its own width.
   assign tick_inc = state_cur.tick_divider + 7'd1;
   assign step_due = (period != '0) && (tick_inc >= period);
   assign level_up = {1'b0, state_cur.pulse_level} + {1'b0, PulseStep};

   always_comb begin
      unique case (mode)
         MODE_DOUBLE: begin
            cycle_len = DoubleCycle;
            on_len    = DoubleOn;
         end
         MODE_TRIPLE: begin
            cycle_len = TripleCycle;
            on_len    = TripleOn;
         end
         MODE_HEART: begin
            cycle_len = HeartCycle;
            on_len    = HeartOn;
         end
         default: begin
            cycle_len = SosLen;
            on_len    = '0;
         end
      endcase
   end

   assign step_cur = (state_cur.step_index < cycle_len) ? state_cur.step_index : '0;
   assign step_inc = step_cur + 6'd1;

   always_comb begin
      stepped              = state_cur;
      stepped.tick_divider = '0;
      case (mode) inside
         MODE_BLINK_SLOW, MODE_BLINK_MID, MODE_BLINK_FAST, MODE_BLINK_VFAST: begin
            stepped.led_on = !state_cur.led_on;
         end
         MODE_DOUBLE, MODE_TRIPLE, MODE_HEART: begin
            stepped.led_on     = (step_cur < on_len) && !step_cur[0];
            stepped.step_index = (step_inc >= cycle_len) ? '0 : step_inc;
         end
         MODE_SOS: begin
            stepped.led_on     = SosPattern[step_cur];
            stepped.step_index = (step_inc >= cycle_len) ? '0 : step_inc;
         end
         MODE_PULSE: begin
            if (state_cur.pulse_rising) begin
               if (level_up >= {1'b0, PulseTop}) begin
                  // The ramp jumps to full scale before it turns round.
                  stepped.pulse_level  = PulseMax;
                  stepped.pulse_rising = 1'b0;
               end else begin
                  stepped.pulse_level = level_up[LevelWidth-1:0];
               end
            end else if (state_cur.pulse_level <= PulseStep) begin
               stepped.pulse_level  = '0;
               stepped.pulse_rising = 1'b1;
            end else begin
               stepped.pulse_level = state_cur.pulse_level - PulseStep;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (restart) begin
         state_nxt = fresh_state(mode);
      end else if (step_due) begin
         state_nxt = stepped;
      end else if (period != '0) begin
         state_nxt              = state_cur;
         state_nxt.tick_divider = tick_inc;
      end else begin
         state_nxt = state_cur;
      end
   end

   always_comb begin
      if (mode == MODE_PULSE) begin
         pin_level  = 1'b0;
         pwm_duty   = state_nxt.pulse_level ^ {LevelWidth{invert}};
         pwm_active = 1'b1;
      end else begin
         pin_level  = state_nxt.led_on ^ invert;
         pwm_duty   = '0;
         pwm_active = 1'b0;
      end
   end

endmodule

`default_nettype wire
